[hdl/alu8f_pkg.sv]
// Shared operation codes, flag positions and transaction types for the 8-bit ALU.
package alu8f_pkg;

   typedef enum logic [4:0] {
      OP_ADD       = 5'd0,
      OP_ADC       = 5'd1,
      OP_SUB       = 5'd2,
      OP_SBC       = 5'd3,
      OP_AND       = 5'd4,
      OP_XOR       = 5'd5,
      OP_OR        = 5'd6,
      OP_CP        = 5'd7,
      OP_RLCA      = 5'd8,
      OP_RRCA      = 5'd9,
      OP_RLA       = 5'd10,
      OP_RRA       = 5'd11,
      OP_DAA       = 5'd12,
      OP_CPL       = 5'd13,
      OP_SCF       = 5'd14,
      OP_CCF       = 5'd15,
      OP_RLC       = 5'd16,
      OP_RRC       = 5'd17,
      OP_RL        = 5'd18,
      OP_RR        = 5'd19,
      OP_SLA       = 5'd20,
      OP_SRA       = 5'd21,
      OP_SWAP      = 5'd22,
      OP_SRL       = 5'd23,
      OP_BIT       = 5'd24,
      OP_RES       = 5'd25,
      OP_SET       = 5'd26,
      OP_INC8      = 5'd27,
      OP_DEC8      = 5'd28,
      OP_ADD16     = 5'd29,
      OP_ADD_SP_E8 = 5'd30
   } op_type;

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [3:0] BCD_MAX_DIGIT = 4'h9;
   localparam logic [7:0] BCD_MAX_BYTE  = 8'h99;

   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  acc;
      logic [7:0]  operand;
      logic [15:0] wide_a;
      logic [15:0] wide_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } alu_req_type;

   typedef struct packed {
      logic [7:0]  result;
      logic [15:0] wide_result;
      logic [3:0]  flags_out;
   } alu_rsp_type;

endpackage

[hdl/eight_bit_alu_with_flags_core.sv]
// Top level of the 8-bit ALU: input register, datapath, result register.
// An accepted request is held in the request register, and its response is valid once it reaches the response register.
// Throughput: one transaction per cycle when not stalled; the datapath sits between the request
// register and the response register, and each stage holds while stalled.
// Reset: synchronous, active high; clears both stage valid flags, payload
// registers are not reset.
module eight_bit_alu_with_flags_core
   import alu8f_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_type,
   input  logic [7:0]  req_acc,
   input  logic [7:0]  req_operand,
   input  logic [15:0] req_wide_a,
   input  logic [15:0] req_wide_b,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_result,
   output logic [15:0] rsp_wide_result,
   output logic [3:0]  rsp_flags_out
);

   alu_req_type stage_ff;
   alu_req_type stage_in;
   logic        stage_valid_ff;
   logic        stage_valid_in;
   alu_rsp_type out_ff;
   alu_rsp_type out_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   alu_rsp_type alu_rsp;
   logic        out_load;
   logic        stage_load;

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign req_stall  = stage_valid_ff && !out_load;
   assign stage_load = !req_stall;

   always_comb begin
      stage_in       = stage_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_load) begin
         stage_in.op        = req_type;
         stage_in.acc       = req_acc;
         stage_in.operand   = req_operand;
         stage_in.wide_a    = req_wide_a;
         stage_in.wide_b    = req_wide_b;
         stage_in.bit_index = req_bit_index;
         stage_in.flags_in  = req_flags_in;
         stage_valid_in     = req_valid;
      end
   end

   alu8f_datapath u_datapath (
      .req (stage_ff),
      .rsp (alu_rsp)
   );

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_in       = alu_rsp;
         out_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_result      = out_ff.result;
   assign rsp_wide_result = out_ff.wide_result;
   assign rsp_flags_out   = out_ff.flags_out;

endmodule

[hdl/alu8f_datapath.sv]
// Combinational ALU datapath: one operation in, result and flags out.
module alu8f_datapath
   import alu8f_pkg::*;
(
   input  alu_req_type req,
   output alu_rsp_type rsp
);

   logic [7:0]  a;
   logic [7:0]  v;
   logic        fz;
   logic        fn;
   logic        fh;
   logic        fc;
   logic        carry_in;
   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_half;
   logic [7:0]  daa_adj;
   logic        daa_carry;
   logic [7:0]  daa_res;
   logic [7:0]  bit_mask;
   logic [16:0] w16_sum;
   logic [12:0] w16_half;
   logic [15:0] sp_sum;
   logic [4:0]  sp_half;
   logic [8:0]  sp_low;
   logic [7:0]  r;
   logic [15:0] w;
   logic [3:0]  fo;

   assign a  = req.acc;
   assign v  = req.operand;
   assign fz = req.flags_in[FLAG_Z];
   assign fn = req.flags_in[FLAG_N];
   assign fh = req.flags_in[FLAG_H];
   assign fc = req.flags_in[FLAG_C];

   assign carry_in = ((op_type'(req.op) == OP_ADC) || (op_type'(req.op) == OP_SBC)) && fc;

   assign add_sum  = {1'b0, a} + {1'b0, v} + {8'd0, carry_in};
   assign add_half = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, carry_in};
   assign sub_diff = {1'b0, a} - {1'b0, v} - {8'd0, carry_in};
   assign sub_half = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, carry_in};

   assign w16_sum  = {1'b0, req.wide_a} + {1'b0, req.wide_b};
   assign w16_half = {1'b0, req.wide_a[11:0]} + {1'b0, req.wide_b[11:0]};
   assign sp_sum   = req.wide_a + {{8{v[7]}}, v};
   assign sp_half  = {1'b0, req.wide_a[3:0]} + {1'b0, v[3:0]};
   assign sp_low   = {1'b0, req.wide_a[7:0]} + {1'b0, v};

   assign bit_mask = 8'd1 << req.bit_index;

   always_comb begin
      daa_adj   = 8'd0;
      daa_carry = fc;
      if (fn) begin
         if (fh) daa_adj = daa_adj | DAA_LOW_ADJ;
         if (fc) daa_adj = daa_adj | DAA_HIGH_ADJ;
         daa_res = a - daa_adj;
      end else begin
         if (fh || (a[3:0] > BCD_MAX_DIGIT)) daa_adj = daa_adj | DAA_LOW_ADJ;
         if (fc || (a > BCD_MAX_BYTE)) begin
            daa_adj   = daa_adj | DAA_HIGH_ADJ;
            daa_carry = 1'b1;
         end
         daa_res = a + daa_adj;
      end
   end

   always_comb begin
      r  = 8'd0;
      w  = 16'd0;
      fo = req.flags_in;
      unique case (op_type'(req.op))
         OP_ADD, OP_ADC: begin
            r  = add_sum[7:0];
            fo = {(add_sum[7:0] == 8'd0), 1'b0, add_half[4], add_sum[8]};
         end
         OP_SUB, OP_SBC: begin
            r  = sub_diff[7:0];
            fo = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
         end
         OP_CP: begin
            r  = a;
            fo = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
         end
         OP_AND: begin
            r  = a & v;
            fo = {((a & v) == 8'd0), 1'b0, 1'b1, 1'b0};
         end
         OP_XOR: begin
            r  = a ^ v;
            fo = {((a ^ v) == 8'd0), 3'b000};
         end
         OP_OR: begin
            r  = a | v;
            fo = {((a | v) == 8'd0), 3'b000};
         end
         OP_RLCA: begin
            r  = {a[6:0], a[7]};
            fo = {3'b000, a[7]};
         end
         OP_RRCA: begin
            r  = {a[0], a[7:1]};
            fo = {3'b000, a[0]};
         end
         OP_RLA: begin
            r  = {a[6:0], fc};
            fo = {3'b000, a[7]};
         end
         OP_RRA: begin
            r  = {fc, a[7:1]};
            fo = {3'b000, a[0]};
         end
         OP_DAA: begin
            r  = daa_res;
            fo = {(daa_res == 8'd0), fn, 1'b0, daa_carry};
         end
         OP_CPL: begin
            r  = ~a;
            fo = {fz, 1'b1, 1'b1, fc};
         end
         OP_SCF: begin
            r  = a;
            fo = {fz, 1'b0, 1'b0, 1'b1};
         end
         OP_CCF: begin
            r  = a;
            fo = {fz, 1'b0, 1'b0, ~fc};
         end
         OP_RLC: begin
            r  = {v[6:0], v[7]};
            fo = {(v == 8'd0), 2'b00, v[7]};
         end
         OP_RRC: begin
            r  = {v[0], v[7:1]};
            fo = {(v == 8'd0), 2'b00, v[0]};
         end
         OP_RL: begin
            r  = {v[6:0], fc};
            fo = {({v[6:0], fc} == 8'd0), 2'b00, v[7]};
         end
         OP_RR: begin
            r  = {fc, v[7:1]};
            fo = {({fc, v[7:1]} == 8'd0), 2'b00, v[0]};
         end
         OP_SLA: begin
            r  = {v[6:0], 1'b0};
            fo = {(v[6:0] == 7'd0), 2'b00, v[7]};
         end
         OP_SRA: begin
            r  = {v[7], v[7:1]};
            fo = {(v[7:1] == 7'd0), 2'b00, v[0]};
         end
         OP_SWAP: begin
            r  = {v[3:0], v[7:4]};
            fo = {(v == 8'd0), 3'b000};
         end
         OP_SRL: begin
            r  = {1'b0, v[7:1]};
            fo = {(v[7:1] == 7'd0), 2'b00, v[0]};
         end
         OP_BIT: begin
            r  = v;
            fo = {((v & bit_mask) == 8'd0), 1'b0, 1'b1, fc};
         end
         OP_RES: begin
            r = v & ~bit_mask;
         end
         OP_SET: begin
            r = v | bit_mask;
         end
         OP_INC8: begin
            r  = v + 8'd1;
            fo = {(v == 8'hFF), 1'b0, (v[3:0] == 4'hF), fc};
         end
         OP_DEC8: begin
            r  = v - 8'd1;
            fo = {(v == 8'h01), 1'b1, (v[3:0] == 4'h0), fc};
         end
         OP_ADD16: begin
            w  = w16_sum[15:0];
            fo = {fz, 1'b0, w16_half[12], w16_sum[16]};
         end
         OP_ADD_SP_E8: begin
            w  = sp_sum;
            fo = {2'b00, sp_half[4], sp_low[8]};
         end
         default: begin
            r  = 8'd0;
            w  = 16'd0;
            fo = req.flags_in;
         end
      endcase
   end

   assign rsp.result      = r;
   assign rsp.wide_result = w;
   assign rsp.flags_out   = fo;

endmodule

[sim/tb.sv]
// Self-checking testbench for the 8-bit ALU core: table-driven corners plus random ops.
`timescale 1ns / 1ps

module tb
   import alu8f_pkg::*;
();

   localparam logic [4:0] OP_UNUSED = 5'd31;
   localparam int TOTAL_ITEMS = 1450;
   localparam int MAX_CYCLES  = 250000;
   localparam int DIR_ROWS    = 36;

   typedef struct packed {
      alu_req_type rq;
      logic        typed;
      alu_rsp_type rsp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [4:0]  req_type;
   logic [7:0]  req_acc;
   logic [7:0]  req_operand;
   logic [15:0] req_wide_a;
   logic [15:0] req_wide_b;
   logic [2:0]  req_bit_index;
   logic [3:0]  req_flags_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_result;
   logic [15:0] rsp_wide_result;
   logic [3:0]  rsp_flags_out;

   alu_rsp_type expected_alu_out [$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          send_burst = 0;

   logic [7:0] corner_bytes [9] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'hFF,
                                    8'h99, 8'h9A};

   dir_row_type dir_table [DIR_ROWS] = '{
      '{'{OP_ADD,       8'hFF, 8'h01, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'hB}},
      '{'{OP_ADC,       8'hFF, 8'hFF, 16'h0, 16'h0, 3'd0, 4'h1}, 1'b1, '{8'hFF, 16'h0, 4'h3}},
      '{'{OP_SUB,       8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'hFF, 16'h0, 4'h7}},
      '{'{OP_SBC,       8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'h1}, 1'b1, '{8'hFF, 16'h0, 4'h7}},
      '{'{OP_AND,       8'hF0, 8'h0F, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'hA}},
      '{'{OP_XOR,       8'hFF, 8'hFF, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'h00, 16'h0, 4'h8}},
      '{'{OP_OR,        8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'h7}, 1'b1, '{8'h00, 16'h0, 4'h8}},
      '{'{OP_CP,        8'h42, 8'h42, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h42, 16'h0, 4'hC}},
      '{'{OP_RLCA,      8'h80, 8'h00, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'h01, 16'h0, 4'h1}},
      '{'{OP_RRCA,      8'h01, 8'h00, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h80, 16'h0, 4'h1}},
      '{'{OP_RLA,       8'h80, 8'h00, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'h1}},
      '{'{OP_RRA,       8'h01, 8'h00, 16'h0, 16'h0, 3'd0, 4'h1}, 1'b1, '{8'h80, 16'h0, 4'h1}},
      '{'{OP_DAA,       8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'h7}, 1'b1, '{8'h9A, 16'h0, 4'h5}},
      '{'{OP_DAA,       8'h9A, 8'h00, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'h9}},
      '{'{OP_CPL,       8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'hFF, 16'h0, 4'h6}},
      '{'{OP_SCF,       8'h55, 8'h00, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'h55, 16'h0, 4'h9}},
      '{'{OP_CCF,       8'hAA, 8'h00, 16'h0, 16'h0, 3'd0, 4'h1}, 1'b1, '{8'hAA, 16'h0, 4'h0}},
      '{'{OP_RLC,       8'h00, 8'h80, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h01, 16'h0, 4'h1}},
      '{'{OP_RRC,       8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'h00, 16'h0, 4'h8}},
      '{'{OP_RL,        8'h00, 8'h80, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'h9}},
      '{'{OP_RR,        8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'h9}},
      '{'{OP_SLA,       8'h00, 8'hFF, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'hFE, 16'h0, 4'h1}},
      '{'{OP_SRA,       8'h00, 8'h81, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'hC0, 16'h0, 4'h1}},
      '{'{OP_SWAP,      8'h00, 8'hA5, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'h5A, 16'h0, 4'h0}},
      '{'{OP_SRL,       8'h00, 8'h01, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'h00, 16'h0, 4'h9}},
      '{'{OP_BIT,       8'h00, 8'h7F, 16'h0, 16'h0, 3'd7, 4'h0}, 1'b1, '{8'h7F, 16'h0, 4'hA}},
      '{'{OP_RES,       8'h00, 8'hFF, 16'h0, 16'h0, 3'd0, 4'hF}, 1'b1, '{8'hFE, 16'h0, 4'hF}},
      '{'{OP_SET,       8'h00, 8'h00, 16'h0, 16'h0, 3'd7, 4'h0}, 1'b1, '{8'h80, 16'h0, 4'h0}},
      '{'{OP_INC8,      8'h00, 8'hFF, 16'h0, 16'h0, 3'd0, 4'h1}, 1'b1, '{8'h00, 16'h0, 4'hB}},
      '{'{OP_DEC8,      8'h00, 8'h00, 16'h0, 16'h0, 3'd0, 4'h0}, 1'b1, '{8'hFF, 16'h0, 4'h6}},
      '{'{OP_ADD16,     8'h00, 8'h00, 16'hFFFF, 16'h0001, 3'd0, 4'h8}, 1'b1,
        '{8'h00, 16'h0000, 4'hB}},
      '{'{OP_ADD_SP_E8, 8'h00, 8'h80, 16'h00FF, 16'h0, 3'd0, 4'hF}, 1'b1,
        '{8'h00, 16'h007F, 4'h1}},
      '{'{OP_UNUSED,    8'hA5, 8'h5A, 16'h1234, 16'h5678, 3'd3, 4'h5}, 1'b1,
        '{8'h00, 16'h0000, 4'h5}},
      '{'{OP_ADD16,     8'h00, 8'h00, 16'h0800, 16'h0800, 3'd0, 4'h0}, 1'b0, '0},
      '{'{OP_DAA,       8'h15, 8'h00, 16'h0, 16'h0, 3'd0, 4'h2}, 1'b0, '0},
      '{'{OP_ADD_SP_E8, 8'h00, 8'h08, 16'hFFF8, 16'h0, 3'd0, 4'h0}, 1'b0, '0}
   };

   eight_bit_alu_with_flags_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_acc         (req_acc),
      .req_operand     (req_operand),
      .req_wide_a      (req_wide_a),
      .req_wide_b      (req_wide_b),
      .req_bit_index   (req_bit_index),
      .req_flags_in    (req_flags_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_wide_result (rsp_wide_result),
      .rsp_flags_out   (rsp_flags_out)
   );

   function automatic alu_rsp_type compute_alu_response(input alu_req_type rq);
      alu_rsp_type o;
      logic        fz, fn, fh, fc, cin, cout;
      logic [7:0]  a, v, r, adj;
      logic [8:0]  sum9;
      logic [4:0]  sum5;
      logic [16:0] sum17;
      logic [12:0] sum13;
      {fz, fn, fh, fc} = rq.flags_in;
      a = rq.acc;
      v = rq.operand;
      r = 8'h00;
      o.result = 8'h00;
      o.wide_result = 16'h0000;
      o.flags_out = rq.flags_in;
      case (rq.op)
         OP_ADD, OP_ADC: begin
            cin = (rq.op == OP_ADC) ? fc : 1'b0;
            sum9 = {1'b0, a} + {1'b0, v} + cin;
            sum5 = {1'b0, a[3:0]} + {1'b0, v[3:0]} + cin;
            o.result = sum9[7:0];
            o.flags_out = {sum9[7:0] == 8'h00, 1'b0, sum5[4], sum9[8]};
         end
         OP_SUB, OP_SBC, OP_CP: begin
            cin = (rq.op == OP_SBC) ? fc : 1'b0;
            sum9 = {1'b0, a} - {1'b0, v} - cin;
            sum5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - cin;
            o.result = (rq.op == OP_CP) ? a : sum9[7:0];
            o.flags_out = {sum9[7:0] == 8'h00, 1'b1, sum5[4], sum9[8]};
         end
         OP_AND: begin
            r = a & v;
            o.result = r;
            o.flags_out = {r == 8'h00, 1'b0, 1'b1, 1'b0};
         end
         OP_XOR, OP_OR: begin
            r = (rq.op == OP_XOR) ? (a ^ v) : (a | v);
            o.result = r;
            o.flags_out = {r == 8'h00, 3'b000};
         end
         OP_RLCA: begin
            o.result = {a[6:0], a[7]};
            o.flags_out = {3'b000, a[7]};
         end
         OP_RRCA: begin
            o.result = {a[0], a[7:1]};
            o.flags_out = {3'b000, a[0]};
         end
         OP_RLA: begin
            o.result = {a[6:0], fc};
            o.flags_out = {3'b000, a[7]};
         end
         OP_RRA: begin
            o.result = {fc, a[7:1]};
            o.flags_out = {3'b000, a[0]};
         end
         OP_DAA: begin
            adj = 8'h00;
            cout = fc;
            if (fn) begin
               if (fh) adj = adj | DAA_LOW_ADJ;
               if (fc) adj = adj | DAA_HIGH_ADJ;
               r = a - adj;
            end else begin
               if (fh || a[3:0] > BCD_MAX_DIGIT) adj = adj | DAA_LOW_ADJ;
               if (fc || a > BCD_MAX_BYTE) begin
                  adj = adj | DAA_HIGH_ADJ;
                  cout = 1'b1;
               end
               r = a + adj;
            end
            o.result = r;
            o.flags_out = {r == 8'h00, fn, 1'b0, cout};
         end
         OP_CPL: begin
            o.result = ~a;
            o.flags_out = {fz, 1'b1, 1'b1, fc};
         end
         OP_SCF: begin
            o.result = a;
            o.flags_out = {fz, 1'b0, 1'b0, 1'b1};
         end
         OP_CCF: begin
            o.result = a;
            o.flags_out = {fz, 1'b0, 1'b0, ~fc};
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
            case (rq.op)
               OP_RLC:  {cout, r} = {v[7], v[6:0], v[7]};
               OP_RRC:  {cout, r} = {v[0], v[0], v[7:1]};
               OP_RL:   {cout, r} = {v[7], v[6:0], fc};
               OP_RR:   {cout, r} = {v[0], fc, v[7:1]};
               OP_SLA:  {cout, r} = {v[7], v[6:0], 1'b0};
               OP_SRA:  {cout, r} = {v[0], v[7], v[7:1]};
               OP_SWAP: {cout, r} = {1'b0, v[3:0], v[7:4]};
               default: {cout, r} = {v[0], 1'b0, v[7:1]};
            endcase
            o.result = r;
            o.flags_out = {r == 8'h00, 1'b0, 1'b0, cout};
         end
         OP_BIT: begin
            o.result = v;
            o.flags_out = {~v[rq.bit_index], 1'b0, 1'b1, fc};
         end
         OP_RES: o.result = v & ~(8'h01 << rq.bit_index);
         OP_SET: o.result = v | (8'h01 << rq.bit_index);
         OP_INC8: begin
            r = v + 8'h01;
            o.result = r;
            o.flags_out = {r == 8'h00, 1'b0, v[3:0] == 4'hF, fc};
         end
         OP_DEC8: begin
            r = v - 8'h01;
            o.result = r;
            o.flags_out = {r == 8'h00, 1'b1, v[3:0] == 4'h0, fc};
         end
         OP_ADD16: begin
            sum17 = {1'b0, rq.wide_a} + {1'b0, rq.wide_b};
            sum13 = {1'b0, rq.wide_a[11:0]} + {1'b0, rq.wide_b[11:0]};
            o.wide_result = sum17[15:0];
            o.flags_out = {fz, 1'b0, sum13[12], sum17[16]};
         end
         OP_ADD_SP_E8: begin
            sum5 = {1'b0, rq.wide_a[3:0]} + {1'b0, v[3:0]};
            sum9 = {1'b0, rq.wide_a[7:0]} + {1'b0, v};
            o.wide_result = rq.wide_a + {{8{v[7]}}, v};
            o.flags_out = {1'b0, 1'b0, sum5[4], sum9[8]};
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic alu_req_type random_alu_req();
      alu_req_type rq;
      rq.op        = 5'($urandom_range(0, 31));
      rq.acc       = 8'($urandom);
      rq.operand   = 8'($urandom);
      rq.wide_a    = 16'($urandom);
      rq.wide_b    = 16'($urandom);
      rq.bit_index = 3'($urandom);
      rq.flags_in  = 4'($urandom);
      if ($urandom_range(0, 3) == 0) rq.operand = corner_bytes[$urandom_range(0, 8)];
      if ($urandom_range(0, 3) == 0) rq.acc = corner_bytes[$urandom_range(0, 8)];
      return rq;
   endfunction

   task automatic issue_alu_req(input alu_req_type rq, input logic typed,
                                input alu_rsp_type typed_rsp);
      int gap;
      if (items_sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type      <= rq.op;
      req_acc       <= rq.acc;
      req_operand   <= rq.operand;
      req_wide_a    <= rq.wide_a;
      req_wide_b    <= rq.wide_b;
      req_bit_index <= rq.bit_index;
      req_flags_in  <= rq.flags_in;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_alu_out.push_back(typed ? typed_rsp : compute_alu_response(rq));
      items_sent++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < MAX_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // receive side: random back-pressure, one long hold-off, field-by-field compare
   initial begin
      int          hold;
      int          seen;
      bit          burst;
      alu_rsp_type want;
      seen = 0;
      burst = 0;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (seen % 64 == 0) burst = ($urandom_range(0, 3) == 0);
         hold = burst ? 0 : $urandom_range(0, 16);
         if (seen == 500) hold = 400;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         seen++;
         if (expected_alu_out.size() == 0) begin
            $display("%0t: unexpected transaction, result %h wide %h flags %h", $time,
                     rsp_result, rsp_wide_result, rsp_flags_out);
            mismatch_count++;
         end else begin
            want = expected_alu_out.pop_front();
            if (rsp_result !== want.result) begin
               $display("%0t: result mismatch, expected %h actual %h", $time,
                        want.result, rsp_result);
               mismatch_count++;
            end
            if (rsp_wide_result !== want.wide_result) begin
               $display("%0t: wide_result mismatch, expected %h actual %h", $time,
                        want.wide_result, rsp_wide_result);
               mismatch_count++;
            end
            if (rsp_flags_out !== want.flags_out) begin
               $display("%0t: flags_out mismatch, expected %h actual %h", $time,
                        want.flags_out, rsp_flags_out);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      alu_req_type rq;
      alu_rsp_type sum_out;
      bit          mid_pause_done;
      mid_pause_done = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= '0;
      req_acc       <= '0;
      req_operand   <= '0;
      req_wide_a    <= '0;
      req_wide_b    <= '0;
      req_bit_index <= '0;
      req_flags_in  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         issue_alu_req(dir_table[i].rq, dir_table[i].typed, dir_table[i].rsp);

      req_valid <= 1'b0;
      while (expected_alu_out.size() != 0) @(posedge clock);

      while (items_sent < TOTAL_ITEMS) begin
         if (!mid_pause_done && items_sent >= 750) begin
            mid_pause_done = 1;
            req_valid <= 1'b0;
            while (expected_alu_out.size() != 0) @(posedge clock);
         end
         rq = random_alu_req();
         if ($urandom_range(0, 5) == 0) begin
            // BCD arithmetic followed by its decimal adjust
            case ($urandom_range(0, 3))
               0: rq.op = OP_ADD;
               1: rq.op = OP_ADC;
               2: rq.op = OP_SUB;
               default: rq.op = OP_SBC;
            endcase
            rq.acc     = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            rq.operand = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            sum_out = compute_alu_response(rq);
            issue_alu_req(rq, 1'b0, '0);
            rq = random_alu_req();
            rq.op       = OP_DAA;
            rq.acc      = sum_out.result;
            rq.flags_in = sum_out.flags_out;
         end
         issue_alu_req(rq, 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (expected_alu_out.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_alu_out.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
